FILE: sv/spf_pkg.sv
package spf_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int LEN_W = 5;
	localparam int POS_W = 16;
	localparam int IDX_W = 2;
	localparam int CFG_W = 64;

	localparam logic [POS_W-1:0] MAX_SCAN = 16'hFFFF;

	// result status codes
	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_PARTIAL = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;
	localparam logic [1:0] ST_LONG    = 2'd3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [IDX_W-1:0] REG_STARTS_WITH    = 2'd3;

	typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] match_start;
		logic [POS_W-1:0] match_end;
	} out_item_t;

	typedef struct packed {
		byte_vec_t        pattern;
		logic [LEN_W-1:0] length;
		logic             prefix_mode;
	} cfg_t;

endpackage

FILE: sv/spf_window_cmp.sv
module spf_window_cmp import spf_pkg::*; (
	input  byte_vec_t              window,
	input  byte_vec_t              pattern,
	output logic [PATTERN_MAX-1:0] tail_match
);

	// tail_match[k-1]: newest k bytes equal pattern bytes 0..k-1
	always_comb begin
		for (int k = 1; k <= PATTERN_MAX; k++) begin
			tail_match[k-1] = 1'b1;
			for (int j = 0; j < k; j++) begin
				if (window[k-1-j] != pattern[j]) begin
					tail_match[k-1] = 1'b0;
				end
			end
		end
	end

endmodule

FILE: sv/spf_scan.sv
module spf_scan import spf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      hit,
	output out_item_t res
);

	byte_vec_t              recent_q;
	byte_vec_t              window;
	logic [POS_W-1:0]       count_q;
	logic                   done_q;
	logic                   failed_q;
	logic [PATTERN_MAX-1:0] tail_match;
	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       len_m1;
	logic [LEN_W-1:0]       k_max;
	logic [LEN_W-1:0]       k_best;
	logic [POS_W-1:0]       count_new;
	logic [POS_W-1:0]       len_ext;
	logic                   too_long;
	logic                   mismatch;
	logic                   found;
	logic                   failed_new;
	logic                   clear;

	always_comb begin
		window[0] = item.data_byte;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			window[i] = recent_q[i-1];
		end
	end

	spf_window_cmp u_cmp (
		.window     (window),
		.pattern    (cfg.pattern),
		.tail_match (tail_match)
	);

	always_comb begin
		if (cfg.length == '0) begin
			len = LEN_W'(1);
		end else if (cfg.length > LEN_W'(PATTERN_MAX)) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = cfg.length;
		end
		len_m1    = len - LEN_W'(1);
		len_ext   = POS_W'(len);
		count_new = count_q + POS_W'(1);
		too_long  = (count_q == MAX_SCAN);

		mismatch = (count_q < len_ext) &&
			(item.data_byte != cfg.pattern[count_q[$clog2(PATTERN_MAX)-1:0]]);

		found      = 1'b0;
		failed_new = failed_q;
		if (cfg.prefix_mode) begin
			if (!failed_q) begin
				if (mismatch) begin
					failed_new = 1'b1;
				end else if (count_new == len_ext) begin
					found = 1'b1;
				end
			end
		end else begin
			found = (count_new >= len_ext) && tail_match[len_m1[$clog2(PATTERN_MAX)-1:0]];
		end

		// longest proper pattern prefix ending at the newest byte
		if (count_new < POS_W'(len_m1)) begin
			k_max = count_new[LEN_W-1:0];
		end else begin
			k_max = len_m1;
		end
		k_best = '0;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			if (tail_match[k-1] && (LEN_W'(k) <= k_max)) begin
				k_best = LEN_W'(k);
			end
		end

		hit   = 1'b0;
		res   = '{status: ST_NONE, match_start: count_new, match_end: count_new};
		clear = item.last_byte;
		if (done_q) begin
			hit = 1'b0;
		end else if (too_long) begin
			hit = 1'b1;
			res = '{status: ST_LONG, match_start: MAX_SCAN, match_end: MAX_SCAN};
		end else if (found) begin
			hit = 1'b1;
			res = '{status: ST_FOUND, match_start: count_new - len_ext,
				match_end: count_new};
		end else if (item.last_byte) begin
			hit = 1'b1;
			if (cfg.prefix_mode) begin
				if (!failed_new) begin
					res = '{status: ST_PARTIAL, match_start: '0, match_end: '0};
				end
			end else if (k_best != '0) begin
				res = '{status: ST_PARTIAL, match_start: count_new - POS_W'(k_best),
					match_end: count_new - POS_W'(k_best)};
			end
		end
	end

	// window holds payload only; reads are bounded by the byte count
	always_ff @(posedge clk) begin
		if (step && !done_q && !too_long) begin
			recent_q <= window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				count_q  <= '0;
				done_q   <= 1'b0;
				failed_q <= 1'b0;
			end else if (!done_q) begin
				if (too_long) begin
					done_q <= 1'b1;
				end else begin
					count_q  <= count_new;
					failed_q <= failed_new;
					done_q   <= found;
				end
			end
		end
	end

endmodule

FILE: sv/streaming_pattern_finder.sv
// Streaming pattern finder: scans a byte stream for a pattern of 1 to 16 bytes.
// Item channel (item_valid/item_ready/item): one byte per transfer, with
// last_byte marking the final byte of a scan. Result channel (result_valid/
// result_ready/result): at most one result per scan -- found, partial match at
// the end of the scan, not found, or scan too long.
// Configuration: wr_en/wr_index/wr_data write the pattern, its length and the
// prefix-only mode; write only while no transfer is in flight.
// Path: a byte is held in the input register, and its result is registered in the
// output register when the byte advances. Throughput: one byte per cycle while
// the result channel does not stall; the whole window of recent bytes is compared
// against every pattern prefix in parallel, combinationally.
// Reset: clears the scan state, the pattern registers (length one) and both
// channel valids.
// When the receiver stalls, the result is held in the output register and the
// input register absorbs one more byte; item_ready then drops until the
// result transfer frees the output register.
module streaming_pattern_finder import spf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	logic [CFG_W-1:0] pattern_low_q;
	logic [CFG_W-1:0] pattern_high_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic             prefix_mode_q;
	cfg_t             cfg;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      hit;
	out_item_t res;
	out_item_t result_q;
	logic      result_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
			prefix_mode_q    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PATTERN_LOW:    pattern_low_q    <= wr_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= wr_data;
				REG_PATTERN_LENGTH: pattern_length_q <= wr_data[LEN_W-1:0];
				REG_STARTS_WITH:    prefix_mode_q    <= wr_data[0];
				default:            prefix_mode_q    <= prefix_mode_q;
			endcase
		end
	end

	assign cfg.pattern     = {pattern_high_q, pattern_low_q};
	assign cfg.length      = pattern_length_q;
	assign cfg.prefix_mode = prefix_mode_q;

	// Advance the held byte only when the output register can take its result.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	spf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.hit    (hit),
		.res    (res)
	);

	// Output register: hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && hit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
